@@ design/nvprp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, record codes and types for the NVMe I/O command PRP engine.
// No dependencies; every other file of the block imports this package.
package nvprp_pkg;

    // Queue and page geometry
    localparam int QUEUE_DEPTH      = 64;
    localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MAX_LIST_ENTRIES = 63;
    localparam int PAGE_BYTES       = 4096;
    localparam int PAGE_SHIFT       = $clog2(PAGE_BYTES);

    // Field widths
    localparam int KIND_W   = 2;
    localparam int REC_W    = 3;
    localparam int OPC_W    = 8;
    localparam int SLOT_W   = 6;
    localparam int LIST_W   = 6;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 16;
    localparam int ADDR_W   = 64;
    localparam int DW_W     = 32;
    localparam int SHIFT_W  = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int SIZE_W   = 32;           // block_count << 15 fits in 31 bits
    localparam int PAGES_W  = SIZE_W + 1 - PAGE_SHIFT;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CPL   = 2'd2;

    // Result record types
    localparam logic [REC_W-1:0] REC_SUB    = 3'd0;
    localparam logic [REC_W-1:0] REC_LIST   = 3'd1;
    localparam logic [REC_W-1:0] REC_OK     = 3'd2;
    localparam logic [REC_W-1:0] REC_ERR    = 3'd3;
    localparam logic [REC_W-1:0] REC_NOTYET = 3'd4;
    localparam logic [REC_W-1:0] REC_REJECT = 3'd5;

    // Command opcodes
    localparam logic [OPC_W-1:0] OPC_WRITE = 8'h01;
    localparam logic [OPC_W-1:0] OPC_READ  = 8'h02;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NAMESPACE_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LBA_SHIFT    = 8'd1;
    localparam logic [SHIFT_W-1:0]   LBA_SHIFT_RST    = 4'd9;

    // Classified work handed from the front end to the back end
    typedef struct packed {
        logic [REC_W-1:0]   rec_type;
        logic [OPC_W-1:0]   opcode;
        logic [ADDR_W-1:0]  lba;
        logic [COUNT_W-1:0] cdw12;
        logic [ADDR_W-1:0]  prp1;
        logic [ADDR_W-1:0]  prp2;
        logic [SLOT_W-1:0]  queue_slot;
        logic [SLOT_W-1:0]  doorbell_value;
        logic [LIST_W-1:0]  n_list;         // list entries to follow, 0 = none
        logic [ADDR_W-1:0]  next_page;      // first list page address
    } t_job;

    // One result beat
    typedef struct packed {
        logic [REC_W-1:0]   rec_type;
        logic [OPC_W-1:0]   opcode;
        logic [DW_W-1:0]    cdw10;
        logic [DW_W-1:0]    cdw11;
        logic [COUNT_W-1:0] cdw12;
        logic [ADDR_W-1:0]  prp1;
        logic [ADDR_W-1:0]  prp2;
        logic [LIST_W-1:0]  list_index;
        logic [ADDR_W-1:0]  list_page;
        logic [SLOT_W-1:0]  queue_slot;
        logic [SLOT_W-1:0]  doorbell_value;
        logic               last;
    } t_res;

endpackage

@@ design/nvprp_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command input, result output, register writes.
// Depends on nvprp_pkg for field widths.

interface nvprp_cmd_if import nvprp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   lba;
    logic [ADDR_W-1:0]   buffer_addr;
    logic [COUNT_W-1:0]  block_count;
    logic [ADDR_W-1:0]   list_addr;
    logic [STATUS_W-1:0] cqe_status;

    modport source (output valid, kind, lba, buffer_addr, block_count, list_addr,
                    cqe_status, input ready);
    modport sink   (input valid, kind, lba, buffer_addr, block_count, list_addr,
                    cqe_status, output ready);
endinterface

interface nvprp_res_if import nvprp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REC_W-1:0]   rec_type;
    logic [OPC_W-1:0]   opcode;
    logic [DW_W-1:0]    cdw10;
    logic [DW_W-1:0]    cdw11;
    logic [COUNT_W-1:0] cdw12;
    logic [ADDR_W-1:0]  prp1;
    logic [ADDR_W-1:0]  prp2;
    logic [LIST_W-1:0]  list_index;
    logic [ADDR_W-1:0]  list_page;
    logic [SLOT_W-1:0]  queue_slot;
    logic [SLOT_W-1:0]  doorbell_value;
    logic               last;

    modport source (output valid, rec_type, opcode, cdw10, cdw11, cdw12, prp1, prp2,
                    list_index, list_page, queue_slot, doorbell_value, last,
                    input ready);
    modport sink   (input valid, rec_type, opcode, cdw10, cdw11, cdw12, prp1, prp2,
                    list_index, list_page, queue_slot, doorbell_value, last,
                    output ready);
endinterface

interface nvprp_cfg_if import nvprp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/nvprp_front.sv @@
`timescale 1ns / 1ps
// Front end: takes command beats and register writes, classifies each item,
// owns the queue pointers and phase. Depends on nvprp_pkg and nvprp_if.
module nvprp_front import nvprp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nvprp_cmd_if.sink  i_cmd,
    nvprp_cfg_if.sink  i_cfg,
    output logic       o_push,
    output t_job       o_job,
    input  logic       i_full
);

    logic                r_hold;
    logic [KIND_W-1:0]   r_kind;
    logic [ADDR_W-1:0]   r_lba;
    logic [ADDR_W-1:0]   r_buf;
    logic [COUNT_W-1:0]  r_count;
    logic [ADDR_W-1:0]   r_list;
    logic [STATUS_W-1:0] r_status;
    logic [SHIFT_W-1:0]  r_lba_shift;
    logic [QPTR_W-1:0]   r_sq_tail;
    logic [QPTR_W-1:0]   r_cq_head;
    logic                r_phase;

    logic [QPTR_W-1:0]   n_sq_tail;
    logic [QPTR_W-1:0]   n_cq_head;
    logic                n_phase;
    logic [QPTR_W-1:0]   tail_inc;
    logic [QPTR_W-1:0]   head_inc;
    logic                head_wrap;

    logic [SIZE_W-1:0]       size;
    logic [PAGE_SHIFT:0]     capacity;
    logic [SIZE_W-1:0]       remaining;
    logic [SIZE_W:0]         round_up;
    logic [PAGES_W-1:0]      pages;
    logic [ADDR_W-1:0]       next_page;
    logic                    fits_one;
    logic                    fits_two;
    logic                    too_long;
    t_job                    n_job;

    assign i_cmd.ready = !r_hold;
    assign i_cfg.ready = 1'b1;
    assign o_push      = r_hold && !i_full;
    assign o_job       = n_job;

    // transfer geometry
    assign size      = SIZE_W'(r_count) << r_lba_shift;
    assign capacity  = (PAGE_SHIFT+1)'(PAGE_BYTES) - {1'b0, r_buf[PAGE_SHIFT-1:0]};
    assign next_page = {r_buf[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
                       + ADDR_W'(PAGE_BYTES);
    assign fits_one  = size <= SIZE_W'(capacity);
    assign remaining = size - SIZE_W'(capacity);
    assign fits_two  = remaining <= SIZE_W'(PAGE_BYTES);
    assign round_up  = {1'b0, remaining} + (SIZE_W+1)'(PAGE_BYTES - 1);
    assign pages     = round_up[SIZE_W:PAGE_SHIFT];
    assign too_long  = !fits_one && !fits_two && (pages > PAGES_W'(MAX_LIST_ENTRIES));

    assign tail_inc  = (r_sq_tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_sq_tail + 1'b1;
    assign head_wrap = r_cq_head == QPTR_W'(QUEUE_DEPTH - 1);
    assign head_inc  = head_wrap ? '0 : r_cq_head + 1'b1;

    always_comb begin
        n_job     = '0;
        n_sq_tail = r_sq_tail;
        n_cq_head = r_cq_head;
        n_phase   = r_phase;
        case (r_kind)
            KIND_READ, KIND_WRITE: begin
                if (r_count == '0 || too_long) begin
                    n_job.rec_type = REC_REJECT;
                end else begin
                    n_job.rec_type       = REC_SUB;
                    n_job.opcode         = (r_kind == KIND_WRITE) ? OPC_WRITE : OPC_READ;
                    n_job.lba            = r_lba;
                    n_job.cdw12          = r_count - 1'b1;
                    n_job.prp1           = r_buf;
                    n_job.queue_slot     = SLOT_W'(r_sq_tail);
                    n_job.doorbell_value = SLOT_W'(tail_inc);
                    n_job.next_page      = next_page;
                    if (fits_one) begin
                        n_job.prp2 = '0;
                    end else if (fits_two) begin
                        n_job.prp2 = next_page;
                    end else begin
                        n_job.prp2   = r_list;
                        n_job.n_list = LIST_W'(pages);
                    end
                    n_sq_tail = tail_inc;
                end
            end
            KIND_CPL: begin
                n_job.queue_slot = SLOT_W'(r_cq_head);
                if (r_status[0] != r_phase) begin
                    n_job.rec_type = REC_NOTYET;
                end else begin
                    n_job.rec_type       = (r_status[STATUS_W-1:1] != '0) ? REC_ERR : REC_OK;
                    n_job.doorbell_value = SLOT_W'(head_inc);
                    n_cq_head            = head_inc;
                    n_phase              = head_wrap ? !r_phase : r_phase;
                end
            end
            default: begin
                n_job.rec_type = REC_REJECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= 1'b0;
            r_lba_shift <= LBA_SHIFT_RST;
            r_sq_tail   <= '0;
            r_cq_head   <= '0;
            r_phase     <= 1'b1;
        end else begin
            // namespace id has no result field: its write is acknowledged only
            if (i_cfg.valid && i_cfg.index == CFG_LBA_SHIFT) begin
                r_lba_shift <= i_cfg.data[SHIFT_W-1:0];
            end
            if (i_cmd.valid && !r_hold) begin
                r_hold <= 1'b1;
            end else if (o_push) begin
                r_hold    <= 1'b0;
                r_sq_tail <= n_sq_tail;
                r_cq_head <= n_cq_head;
                r_phase   <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && !r_hold) begin
            r_kind   <= i_cmd.kind;
            r_lba    <= i_cmd.lba;
            r_buf    <= i_cmd.buffer_addr;
            r_count  <= i_cmd.block_count;
            r_list   <= i_cmd.list_addr;
            r_status <= i_cmd.cqe_status;
        end
    end

endmodule

@@ design/nvprp_queue.sv @@
`timescale 1ns / 1ps
// Two-entry job queue between the front and back ends.
// Depends on nvprp_pkg for t_job.
module nvprp_queue import nvprp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ design/nvprp_back.sv @@
`timescale 1ns / 1ps
// Back end: turns a queued job into the command beat and its PRP list beats,
// through a registered output stage. Depends on nvprp_pkg and nvprp_if.
module nvprp_back import nvprp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_empty,
    output logic        o_pop,
    nvprp_res_if.source o_res
);

    logic              r_act;
    logic              r_in_list;
    t_job              r_job;
    logic [LIST_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_page;
    logic              r_out_valid;
    t_res              r_out;

    logic              load;
    logic              list_last;
    t_res              n_out;

    assign o_pop     = !r_act && !i_empty;
    assign load      = !r_out_valid || o_res.ready;
    assign list_last = (r_idx + 1'b1) == r_job.n_list;

    always_comb begin
        n_out = '0;
        if (!r_in_list) begin
            n_out.rec_type       = r_job.rec_type;
            n_out.opcode         = r_job.opcode;
            n_out.cdw10          = r_job.lba[DW_W-1:0];
            n_out.cdw11          = r_job.lba[ADDR_W-1:DW_W];
            n_out.cdw12          = r_job.cdw12;
            n_out.prp1           = r_job.prp1;
            n_out.prp2           = r_job.prp2;
            n_out.queue_slot     = r_job.queue_slot;
            n_out.doorbell_value = r_job.doorbell_value;
            n_out.last           = r_job.n_list == '0;
        end else begin
            n_out.rec_type   = REC_LIST;
            n_out.list_index = r_idx;
            n_out.list_page  = r_page;
            n_out.last       = list_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_in_list   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act     <= 1'b1;
                r_in_list <= 1'b0;
            end else if (r_act && load) begin
                if (!r_in_list) begin
                    if (r_job.n_list == '0) begin
                        r_act <= 1'b0;
                    end else begin
                        r_in_list <= 1'b1;
                    end
                end else if (list_last) begin
                    r_act <= 1'b0;
                end
            end
            if (r_act && load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_idx  <= '0;
            r_page <= i_job.next_page;
        end else if (r_act && load && r_in_list) begin
            r_idx  <= r_idx + 1'b1;
            r_page <= r_page + ADDR_W'(PAGE_BYTES);
        end
        if (r_act && load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.rec_type       = r_out.rec_type;
    assign o_res.opcode         = r_out.opcode;
    assign o_res.cdw10          = r_out.cdw10;
    assign o_res.cdw11          = r_out.cdw11;
    assign o_res.cdw12          = r_out.cdw12;
    assign o_res.prp1           = r_out.prp1;
    assign o_res.prp2           = r_out.prp2;
    assign o_res.list_index     = r_out.list_index;
    assign o_res.list_page      = r_out.list_page;
    assign o_res.queue_slot     = r_out.queue_slot;
    assign o_res.doorbell_value = r_out.doorbell_value;
    assign o_res.last           = r_out.last;

endmodule

@@ design/nvme_io_command_prp_engine.sv @@
`timescale 1ns / 1ps
// NVMe I/O queue-pair command engine with PRP setup: top level.
// Depends on nvprp_pkg, nvprp_if, nvprp_front, nvprp_queue and nvprp_back.
//
// Channels:
//   i_cmd - one beat per item: read/write submit or a completion seen at head.
//   o_res - result beats; a submit gives the command beat, then one beat per
//           PRP list entry; every other item gives exactly one beat. last marks
//           the final beat of an item.
//   i_cfg - register writes (index 1 = lba_shift). The namespace id (index 0)
//           feeds no result field, so its write is acknowledged and dropped.
// Path: from accept to the first result beat an item passes the input register,
//   classify and queue push, back end load and the output register.
// Overlap: the front end takes no new item until the held one is pushed; the
//   back end pops a job only after loading the last beat of the one before,
//   the command beat and then one beat per list entry.
// Reset: tail and head go to zero, the expected phase to one, lba_shift to 9.
// Stall: when o_res.ready is low the output register holds, the back end
//   stops, the two-entry job queue fills, then i_cmd.ready drops.
module nvme_io_command_prp_engine import nvprp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nvprp_cmd_if.sink   i_cmd,
    nvprp_res_if.source o_res,
    nvprp_cfg_if.sink   i_cfg
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job front_job;
    t_job queue_job;

    // classification and queue pointer bookkeeping
    nvprp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_cfg   (i_cfg),
        .o_push  (push),
        .o_job   (front_job),
        .i_full  (full)
    );

    // decouples the two halves so each stalls on its own
    nvprp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty)
    );

    // beat generation, including the PRP list walk
    nvprp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (queue_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
